/* rtl/hsvc_pkg.sv */
// Package: beat types and hue sector constants for the HSV to RGB converter.
`default_nettype none
package hsvc_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 16;

  localparam logic [HueW-1:0] HueSector = 16'd255;
  localparam logic [HueW-1:0] HueEdge2  = 16'd510;
  localparam logic [HueW-1:0] HueEdge3  = 16'd765;
  localparam logic [HueW-1:0] HueEdge4  = 16'd1020;
  localparam logic [HueW-1:0] HueEdge5  = 16'd1275;
  localparam logic [HueW-1:0] HueWrap   = 16'd1530;

  localparam logic [ChanW-1:0] ChanFull = 8'hff;
  localparam logic [ChanW-1:0] ChanZero = 8'h00;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] value;
  } hsv_beat_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_beat_t;

  // Raw sector color plus the scale factors carried down the pipe.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] value;
  } raw_beat_t;

endpackage
`default_nettype wire

/* rtl/hsvc_sector.sv */
// Stage 1: hue sector decode into raw red, green and blue.
`default_nettype none
module hsvc_sector (
  input  wire logic               clk,
  input  wire hsvc_pkg::hsv_beat_t hsv,
  output hsvc_pkg::raw_beat_t     raw
);
  import hsvc_pkg::*;

  raw_beat_t raw_r;
  raw_beat_t raw_nxt;
  logic [HueW-1:0] up_ramp;
  logic [HueW-1:0] dn_ramp;

  always_comb begin
    raw_nxt.saturation = hsv.saturation;
    raw_nxt.value      = hsv.value;
    up_ramp = '0;
    dn_ramp = '0;
    raw_nxt.red   = ChanFull;
    raw_nxt.green = ChanZero;
    raw_nxt.blue  = ChanZero;
    if (hsv.hue < HueSector) begin
      raw_nxt.green = hsv.hue[ChanW-1:0];
    end else if (hsv.hue < HueEdge2) begin
      dn_ramp       = HueEdge2 - hsv.hue;
      raw_nxt.red   = dn_ramp[ChanW-1:0];
      raw_nxt.green = ChanFull;
    end else if (hsv.hue < HueEdge3) begin
      up_ramp       = hsv.hue - HueEdge2;
      raw_nxt.red   = ChanZero;
      raw_nxt.green = ChanFull;
      raw_nxt.blue  = up_ramp[ChanW-1:0];
    end else if (hsv.hue < HueEdge4) begin
      dn_ramp       = HueEdge4 - hsv.hue;
      raw_nxt.red   = ChanZero;
      raw_nxt.green = dn_ramp[ChanW-1:0];
      raw_nxt.blue  = ChanFull;
    end else if (hsv.hue < HueEdge5) begin
      up_ramp       = hsv.hue - HueEdge4;
      raw_nxt.red   = up_ramp[ChanW-1:0];
      raw_nxt.blue  = ChanFull;
    end else if (hsv.hue < HueWrap) begin
      dn_ramp       = HueWrap - hsv.hue;
      raw_nxt.blue  = dn_ramp[ChanW-1:0];
    end
    // hue past the last sector: pure red, the defaults above
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
  end

  assign raw = raw_r;

endmodule
`default_nettype wire

/* rtl/hsvc_shade.sv */
// Stages 2 and 3: desaturate one channel, then scale by value.
`default_nettype none
module hsvc_shade (
  input  wire logic       clk,
  input  wire logic [7:0] chan_raw,
  input  wire logic [7:0] saturation,
  input  wire logic [7:0] value,
  output logic [7:0]      chan_out
);
  import hsvc_pkg::*;

  logic [ChanW:0]       sat_p1;
  logic [2*ChanW:0]     sat_prod;
  logic [ChanW:0]       desat_sum;
  logic [ChanW-1:0]     desat_r;
  logic [ChanW-1:0]     desat_nxt;
  logic [ChanW-1:0]     value_r;
  logic [ChanW:0]       val_p1;
  logic [2*ChanW:0]     val_prod;
  logic [ChanW-1:0]     chan_r;
  logic [ChanW-1:0]     chan_nxt;

  // sum never exceeds 255, so the top bit drops
  always_comb begin
    sat_p1    = {1'b0, saturation} + 9'd1;
    sat_prod  = {9'd0, chan_raw} * {8'd0, sat_p1};
    desat_sum = sat_prod[2*ChanW-1:ChanW] + {1'b0, ChanFull - saturation};
    desat_nxt = desat_sum[ChanW-1:0];
  end

  always_comb begin
    val_p1   = {1'b0, value_r} + 9'd1;
    val_prod = {9'd0, desat_r} * {8'd0, val_p1};
    chan_nxt = val_prod[2*ChanW-1:ChanW];
  end

  always_ff @(posedge clk) begin
    desat_r <= desat_nxt;
    value_r <= value;
    chan_r  <= chan_nxt;
  end

  assign chan_out = chan_r;

endmodule
`default_nettype wire

/* rtl/hsv_to_rgb_color_convert.sv */
// Top level: three-stage HSV to RGB pixel pipeline.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+----------------------------------------
//  input    | start, busy, in_data  | beat taken at edge with start & !busy
//  result   | out_strobe, out_data  | one-cycle strobe, always taken
//
// Between the accepting edge and the strobe, a beat passes three registers in order:
// sector decode, desaturate multiply and value multiply.
// A new beat can enter every cycle while busy is low; at most one result leaves per cycle.
// busy is high only during reset and the cycle after; afterward it stays low.
// Reset (rst_n, synchronous) clears the valid bits; data registers are not reset.
// The receiver cannot stall, so the pipe never holds and drops nothing.
`default_nettype none
module hsv_to_rgb_color_convert (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire hsvc_pkg::hsv_beat_t in_data,
  output logic                     out_strobe,
  output hsvc_pkg::rgb_beat_t      out_data
);
  import hsvc_pkg::*;

  // valid bits, one per stage
  logic [2:0]       vld_r;
  logic [2:0]       vld_nxt;
  logic             busy_r;
  logic             accept;
  raw_beat_t        raw;
  // per-lane results, packed into the result beat below
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;

  assign accept = start & ~busy_r;

  always_comb begin
    vld_nxt = {vld_r[1:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      busy_r <= 1'b1;
    end else begin
      vld_r  <= vld_nxt;
      busy_r <= 1'b0;
    end
  end

  // stage 1: sector decode
  hsvc_sector u_sector (
    .clk (clk),
    .hsv (in_data),
    .raw (raw)
  );

  // stages 2 and 3, one lane per channel
  hsvc_shade u_shade_red (
    .clk        (clk),
    .chan_raw   (raw.red),
    .saturation (raw.saturation),
    .value      (raw.value),
    .chan_out   (red_out)
  );

  hsvc_shade u_shade_green (
    .clk        (clk),
    .chan_raw   (raw.green),
    .saturation (raw.saturation),
    .value      (raw.value),
    .chan_out   (green_out)
  );

  hsvc_shade u_shade_blue (
    .clk        (clk),
    .chan_raw   (raw.blue),
    .saturation (raw.saturation),
    .value      (raw.value),
    .chan_out   (blue_out)
  );

  assign busy       = busy_r;
  assign out_strobe = vld_r[2];
  assign out_data   = {red_out, green_out, blue_out};

endmodule
`default_nettype wire
